// ----- sv/smp_pkg.sv -----
// ----------------------------------------------------------------------------
// smp_pkg
// Shared types and constants for the splitter-based multiway partitioner.
// ----------------------------------------------------------------------------
package smp_pkg;

  localparam int MaxSplitters = 1024;
  localparam int MaxElements  = 4096;
  localparam int SplW  = $clog2(MaxSplitters);      // splitter index
  localparam int SplCW = SplW + 1;                  // splitter count
  localparam int ElW   = $clog2(MaxElements);       // element index
  localparam int ElCW  = ElW + 1;                   // element count
  localparam int DataW = 64;

  typedef enum logic [2:0] {
    CMD_LOAD_SPL  = 3'd0,
    CMD_LOAD_VAL  = 3'd1,
    CMD_PARTITION = 3'd2,
    CMD_RD_START  = 3'd3,
    CMD_RD_OUT    = 3'd4,
    CMD_CLEAR     = 3'd5,
    CMD_NOP6      = 3'd6,
    CMD_NOP7      = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,        // zero the tallies
    S_CLS_RD,     // read element i
    S_CLS_WAIT,   // element data registered
    S_CLS_FETCH,  // read splitter[mid] for the next search step
    S_CLS_CMP,    // one search step on the fetched splitter
    S_CLS_TRD,    // read tally of found bucket
    S_CLS_TWR,    // increment tally
    S_PFX_RD,     // read tally j
    S_PFX_WR,     // write start and next
    S_SCT_RD,     // read element bucket and data
    S_SCT_NRD,    // read next slot of bucket
    S_SCT_WR,     // write partitioned store, bump next
    S_RD_WAIT,    // memory read latency for read commands
    S_DONE
  } state_e;

  // control from sequencer to the search unit
  typedef struct packed {
    logic init;   // load lo/hi bounds
    logic step;   // apply one compare
  } srch_ctl_t;

endpackage

// ----- sv/smp_search.sv -----
// ----------------------------------------------------------------------------
// smp_search
// Shared compare unit: one binary search step per compare cycle over the splitters.
// ----------------------------------------------------------------------------
module smp_search (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  smp_pkg::srch_ctl_t        ctl_i,
  input  logic [smp_pkg::SplCW-1:0] count_i,
  input  logic [smp_pkg::DataW-1:0] value_i,
  input  logic [smp_pkg::DataW-1:0] splitter_i,
  output logic [smp_pkg::SplW-1:0]  mid_o,
  output logic                      done_o,
  output logic [smp_pkg::SplW-1:0]  bucket_o
);

  logic [smp_pkg::SplW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [smp_pkg::SplW:0]   sum;
  logic                     less;

  // midpoint and signed compare
  assign sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_o  = sum[smp_pkg::SplW:1];
  assign less   = $signed(value_i) < $signed(splitter_i);
  assign done_o = !(lo_q < hi_q);
  assign bucket_o = lo_q;

  // bound update
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctl_i.init) begin
      lo_d = '0;
      hi_d = smp_pkg::SplW'(count_i - smp_pkg::SplCW'(1));
    end else if (ctl_i.step && !done_o) begin
      if (less) begin
        hi_d = mid_o;
      end else begin
        lo_d = mid_o + smp_pkg::SplW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

`ifndef SYNTHESIS
  a_lo_le_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ctl_i.step) && !$past(ctl_i.init) && $past(lo_q <= hi_q) |-> lo_q <= hi_q)
    else $error("search bounds crossed");
  a_init_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.init |=> lo_q == '0)
    else $error("search init failed");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ctl_i.init |=> $stable(lo_q))
    else $error("search moved after done");
`endif

endmodule

// ----- sv/splitter_multi_partition.sv -----
// ----------------------------------------------------------------------------
// splitter_multi_partition
// Multiway partition of loaded values by ascending splitters.
// ----------------------------------------------------------------------------
// Usage: drive cmd_i, data_word_i and read_index_i and pulse start_i while
// busy_o is low; the command transfers at that edge. Exactly one result per
// command appears on read_data_o/status_o for one cycle with done_o high.
// Loads, clear and unused commands go straight to the result state; reads
// pass through a wait state (registered memory read). Partition runs in a
// sequencer around one shared compare unit: S tally clears, classification
// of each value (each search step reads splitter[mid] in S_CLS_FETCH and
// compares in S_CLS_CMP), a prefix sum over the tallies and a scatter of
// each value into its bucket, for S splitters and N values.
// busy_o is high from the transfer until the result cycle. The receiver
// cannot stall; results must be taken in their cycle. Reset clears counts
// and the valid flag; memory contents are undefined until written, and no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module splitter_multi_partition (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  cmd_i,
  input  logic [63:0] data_word_i,
  input  logic [11:0] read_index_i,
  output logic        done_o,
  output logic [63:0] read_data_o,
  output logic [1:0]  status_o
);

  localparam int SW = smp_pkg::SplW;
  localparam int SC = smp_pkg::SplCW;
  localparam int EW = smp_pkg::ElW;
  localparam int EC = smp_pkg::ElCW;
  localparam int DW = smp_pkg::DataW;

  // memories
  logic [DW-1:0] spl_mem  [smp_pkg::MaxSplitters];
  logic [DW-1:0] el_mem   [smp_pkg::MaxElements];
  logic [SW-1:0] bkt_mem  [smp_pkg::MaxElements];
  logic [EC-1:0] tly_mem  [smp_pkg::MaxSplitters];
  logic [EC-1:0] strt_mem [smp_pkg::MaxSplitters];
  logic [EC-1:0] nxt_mem  [smp_pkg::MaxSplitters];
  logic [DW-1:0] out_mem  [smp_pkg::MaxElements];

  smp_pkg::state_e state_q, state_d;
  logic [SC-1:0] spl_cnt_q, spl_cnt_d;
  logic [EC-1:0] el_cnt_q, el_cnt_d;
  logic          pvalid_q, pvalid_d;
  logic [2:0]    cmd_q;
  logic [11:0]   idx_q;
  logic [EC-1:0] i_q, i_d;        // element walker / tally / prefix index
  logic [EC-1:0] acc_q, acc_d;
  logic [1:0]    status_q, status_d;
  logic          rd_sel_q, rd_sel_d; // 1 returns memory data

  // registered memory read data
  logic [DW-1:0] spl_rd_q, el_rd_q, out_rd_q;
  logic [SW-1:0] bkt_rd_q;
  logic [EC-1:0] tly_rd_q, strt_rd_q, nxt_rd_q;
  logic [DW-1:0] val_q;           // element under classification or scatter

  smp_pkg::srch_ctl_t srch_ctl;
  logic [SW-1:0]      mid;
  logic               srch_done;
  logic [SW-1:0]      bucket;

  smp_search u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (srch_ctl),
    .count_i    (spl_cnt_q),
    .value_i    (val_q),
    .splitter_i (spl_rd_q),
    .mid_o      (mid),
    .done_o     (srch_done),
    .bucket_o   (bucket)
  );

  logic [SW-1:0] bucket_q;
  logic [SW-1:0] i_spl;
  logic [EW-1:0] i_el;
  logic [SW-1:0] idx_spl;
  logic [EW-1:0] idx_el;
  logic          last_spl, last_el;
  logic          accept;

  assign accept   = start_i && !busy_o;
  assign i_spl    = i_q[SW-1:0];
  assign i_el     = i_q[EW-1:0];
  assign idx_spl  = idx_q[SW-1:0];
  assign idx_el   = idx_q[EW-1:0];
  assign last_spl = (i_q + EC'(1)) >= EC'(spl_cnt_q);
  assign last_el  = (i_q + EC'(1)) >= el_cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smp_pkg::S_IDLE: begin
        if (accept) begin
          priority case (smp_pkg::cmd_e'(cmd_i))
            smp_pkg::CMD_PARTITION:
              state_d = (spl_cnt_q == '0) ? smp_pkg::S_DONE : smp_pkg::S_CLR;
            smp_pkg::CMD_RD_START, smp_pkg::CMD_RD_OUT: state_d = smp_pkg::S_RD_WAIT;
            default: state_d = smp_pkg::S_DONE;
          endcase
        end
      end
      smp_pkg::S_CLR:
        if (last_spl) begin
          state_d = (el_cnt_q == '0) ? smp_pkg::S_PFX_RD : smp_pkg::S_CLS_RD;
        end
      smp_pkg::S_CLS_RD:    state_d = smp_pkg::S_CLS_WAIT;
      smp_pkg::S_CLS_WAIT:  state_d = smp_pkg::S_CLS_FETCH;
      smp_pkg::S_CLS_FETCH:
        state_d = srch_done ? smp_pkg::S_CLS_TRD : smp_pkg::S_CLS_CMP;
      smp_pkg::S_CLS_CMP:   state_d = smp_pkg::S_CLS_FETCH;
      smp_pkg::S_CLS_TRD:   state_d = smp_pkg::S_CLS_TWR;
      smp_pkg::S_CLS_TWR:
        state_d = last_el ? smp_pkg::S_PFX_RD : smp_pkg::S_CLS_RD;
      smp_pkg::S_PFX_RD:   state_d = smp_pkg::S_PFX_WR;
      smp_pkg::S_PFX_WR:
        if (last_spl) begin
          state_d = (el_cnt_q == '0) ? smp_pkg::S_DONE : smp_pkg::S_SCT_RD;
        end else begin
          state_d = smp_pkg::S_PFX_RD;
        end
      smp_pkg::S_SCT_RD:   state_d = smp_pkg::S_SCT_NRD;
      smp_pkg::S_SCT_NRD:  state_d = smp_pkg::S_SCT_WR;
      smp_pkg::S_SCT_WR:
        state_d = last_el ? smp_pkg::S_DONE : smp_pkg::S_SCT_RD;
      smp_pkg::S_RD_WAIT:  state_d = smp_pkg::S_DONE;
      smp_pkg::S_DONE:     state_d = smp_pkg::S_IDLE;
      default:             state_d = smp_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs and bookkeeping
  always_comb begin
    spl_cnt_d = spl_cnt_q;
    el_cnt_d  = el_cnt_q;
    pvalid_d  = pvalid_q;
    i_d       = i_q;
    acc_d     = acc_q;
    status_d  = status_q;
    rd_sel_d  = rd_sel_q;
    srch_ctl  = '0;
    unique case (state_q)
      smp_pkg::S_IDLE: begin
        i_d   = '0;
        acc_d = '0;
        if (accept) begin
          status_d = smp_pkg::ST_OK;
          rd_sel_d = 1'b0;
          priority case (smp_pkg::cmd_e'(cmd_i))
            smp_pkg::CMD_LOAD_SPL:
              if (spl_cnt_q >= SC'(smp_pkg::MaxSplitters)) begin
                status_d = smp_pkg::ST_FULL;
              end else begin
                spl_cnt_d = spl_cnt_q + SC'(1);
                pvalid_d  = 1'b0;
              end
            smp_pkg::CMD_LOAD_VAL:
              if (el_cnt_q >= EC'(smp_pkg::MaxElements)) begin
                status_d = smp_pkg::ST_FULL;
              end else begin
                el_cnt_d = el_cnt_q + EC'(1);
                pvalid_d = 1'b0;
              end
            smp_pkg::CMD_PARTITION:
              if (spl_cnt_q == '0) status_d = smp_pkg::ST_INVALID;
            smp_pkg::CMD_RD_START:
              if (!pvalid_q) status_d = smp_pkg::ST_INVALID;
              else if (12'(read_index_i) >= 12'(spl_cnt_q)) status_d = smp_pkg::ST_RANGE;
              else rd_sel_d = 1'b1;
            smp_pkg::CMD_RD_OUT:
              if (!pvalid_q) status_d = smp_pkg::ST_INVALID;
              else if (EC'(read_index_i) >= el_cnt_q) status_d = smp_pkg::ST_RANGE;
              else rd_sel_d = 1'b1;
            smp_pkg::CMD_CLEAR: begin
              spl_cnt_d = '0;
              el_cnt_d  = '0;
              pvalid_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      smp_pkg::S_CLR: i_d = last_spl ? '0 : i_q + EC'(1);
      smp_pkg::S_CLS_WAIT: srch_ctl.init = 1'b1;
      smp_pkg::S_CLS_CMP:  srch_ctl.step = 1'b1;
      smp_pkg::S_CLS_TWR:  i_d = last_el ? '0 : i_q + EC'(1);
      smp_pkg::S_PFX_WR: begin
        acc_d = acc_q + tly_rd_q;
        i_d   = last_spl ? '0 : i_q + EC'(1);
        if (last_spl && el_cnt_q == '0) pvalid_d = 1'b1;
      end
      smp_pkg::S_SCT_WR: begin
        i_d = i_q + EC'(1);
        if (last_el) pvalid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == smp_pkg::CMD_LOAD_SPL && spl_cnt_q < SC'(smp_pkg::MaxSplitters)) begin
      spl_mem[spl_cnt_q[SW-1:0]] <= data_word_i;
    end
    spl_rd_q <= spl_mem[mid];
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == smp_pkg::CMD_LOAD_VAL && el_cnt_q < EC'(smp_pkg::MaxElements)) begin
      el_mem[el_cnt_q[EW-1:0]] <= data_word_i;
    end
    el_rd_q <= el_mem[i_el];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == smp_pkg::S_CLS_TRD) begin
      bkt_mem[i_el] <= bucket;
    end
    bkt_rd_q <= bkt_mem[i_el];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == smp_pkg::S_CLR) begin
      tly_mem[i_spl] <= '0;
    end else if (state_q == smp_pkg::S_CLS_TWR) begin
      tly_mem[bucket_q] <= tly_rd_q + EC'(1);
    end
    tly_rd_q <= tly_mem[(state_q == smp_pkg::S_CLS_TRD) ? bucket : i_spl];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == smp_pkg::S_PFX_WR) begin
      strt_mem[i_spl] <= acc_q;
    end
    strt_rd_q <= strt_mem[idx_spl];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == smp_pkg::S_PFX_WR) begin
      nxt_mem[i_spl] <= acc_q;
    end else if (state_q == smp_pkg::S_SCT_WR) begin
      nxt_mem[bkt_rd_q] <= nxt_rd_q + EC'(1);
    end
    nxt_rd_q <= nxt_mem[bkt_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == smp_pkg::S_SCT_WR && !nxt_rd_q[EC-1]) begin
      out_mem[nxt_rd_q[EW-1:0]] <= val_q;
    end
    out_rd_q <= out_mem[idx_el];
  end

  // value, bucket and read index holding registers
  always_ff @(posedge clk_i) begin
    if (state_q == smp_pkg::S_CLS_WAIT || state_q == smp_pkg::S_SCT_NRD) begin
      val_q <= el_rd_q;
    end
    if (state_q == smp_pkg::S_CLS_TRD) begin
      bucket_q <= bucket;
    end
    if (accept) begin
      idx_q  <= read_index_i;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= smp_pkg::S_IDLE;
      spl_cnt_q <= '0;
      el_cnt_q  <= '0;
      pvalid_q  <= 1'b0;
      i_q       <= '0;
      acc_q     <= '0;
      status_q  <= '0;
      rd_sel_q  <= 1'b0;
      cmd_q     <= '0;
    end else begin
      state_q   <= state_d;
      spl_cnt_q <= spl_cnt_d;
      el_cnt_q  <= el_cnt_d;
      pvalid_q  <= pvalid_d;
      i_q       <= i_d;
      acc_q     <= acc_d;
      status_q  <= status_d;
      rd_sel_q  <= rd_sel_d;
      if (accept) cmd_q <= cmd_i;
    end
  end

  // result port
  assign busy_o = state_q != smp_pkg::S_IDLE;
  assign done_o = state_q == smp_pkg::S_DONE;
  always_comb begin
    read_data_o = '0;
    if (done_o && rd_sel_q) begin
      read_data_o = (cmd_q == smp_pkg::CMD_RD_START) ? DW'(strt_rd_q) : out_rd_q;
    end
  end
  assign status_o = done_o ? status_q : smp_pkg::ST_OK;

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("not busy after transfer");
  a_read_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rd_sel_q |-> pvalid_q)
    else $error("read data without valid partition");
  a_spl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spl_cnt_q <= SC'(smp_pkg::MaxSplitters))
    else $error("splitter count overflow");
`endif

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the splitter-based multiway partitioner against a behavioral model
// of the load, partition, read, clear and unused commands, with random gaps between
// command transfers and a check of every result strobe.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  cmd_i;
  logic [63:0] data_word_i;
  logic [11:0] read_index_i;
  logic        done_o;
  logic [63:0] read_data_o;
  logic [1:0]  status_o;

  splitter_multi_partition dut (.*);

  typedef struct {
    logic [63:0]      data;
    smp_pkg::status_e status;
  } result_t;

  // model state
  logic signed [63:0] spl_tab [smp_pkg::MaxSplitters];
  int                 spl_cnt;
  logic signed [63:0] val_tab [smp_pkg::MaxElements];
  int                 val_cnt;
  int                 bkt_start [smp_pkg::MaxSplitters];
  logic [63:0]        part_tab [smp_pkg::MaxElements];
  bit                 part_ok;

  result_t expected_q [$];
  int      errors;
  int      idle_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // first splitter greater than the value, clamped to the last bucket
  function automatic int bucket_of(logic signed [63:0] v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = spl_cnt - 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (v < spl_tab[mid]) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic void do_partition();
    int tally [smp_pkg::MaxSplitters];
    int nxt [smp_pkg::MaxSplitters];
    int bk [smp_pkg::MaxElements];
    int acc;
    acc = 0;
    for (int i = 0; i < spl_cnt; i++) tally[i] = 0;
    for (int i = 0; i < val_cnt; i++) begin
      bk[i] = bucket_of(val_tab[i]);
      tally[bk[i]]++;
    end
    for (int i = 0; i < spl_cnt; i++) begin
      bkt_start[i] = acc;
      nxt[i] = acc;
      acc += tally[i];
    end
    for (int i = 0; i < val_cnt; i++) begin
      part_tab[nxt[bk[i]]] = val_tab[i];
      nxt[bk[i]]++;
    end
    part_ok = 1'b1;
  endfunction

  function automatic result_t predict_result(smp_pkg::cmd_e c, logic [63:0] w,
                                             logic [11:0] idx);
    result_t r;
    r.data = '0;
    r.status = smp_pkg::ST_OK;
    case (c)
      smp_pkg::CMD_LOAD_SPL: begin
        if (spl_cnt >= smp_pkg::MaxSplitters) r.status = smp_pkg::ST_FULL;
        else begin
          spl_tab[spl_cnt++] = w;
          part_ok = 1'b0;
        end
      end
      smp_pkg::CMD_LOAD_VAL: begin
        if (val_cnt >= smp_pkg::MaxElements) r.status = smp_pkg::ST_FULL;
        else begin
          val_tab[val_cnt++] = w;
          part_ok = 1'b0;
        end
      end
      smp_pkg::CMD_PARTITION: begin
        if (spl_cnt == 0) r.status = smp_pkg::ST_INVALID;
        else do_partition();
      end
      smp_pkg::CMD_RD_START: begin
        if (!part_ok) r.status = smp_pkg::ST_INVALID;
        else if (idx >= spl_cnt) r.status = smp_pkg::ST_RANGE;
        else r.data = 64'(bkt_start[idx]);
      end
      smp_pkg::CMD_RD_OUT: begin
        if (!part_ok) r.status = smp_pkg::ST_INVALID;
        else if (idx >= val_cnt) r.status = smp_pkg::ST_RANGE;
        else r.data = part_tab[idx];
      end
      smp_pkg::CMD_CLEAR: begin
        spl_cnt = 0;
        val_cnt = 0;
        part_ok = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // one command transfer, with a random gap before it; the block is idle here
  task automatic send_cmd(smp_pkg::cmd_e c, logic [63:0] w = '0, logic [11:0] idx = '0);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) @(posedge clk_i);
    start_i      <= 1'b1;
    cmd_i        <= c;
    data_word_i  <= w;
    read_index_i <= idx;
    expected_q.push_back(predict_result(c, w, idx));
    @(posedge clk_i);
    start_i <= 1'b0;
    // wait for the result so the model matches the block's order
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random value, often near a splitter so buckets get exercised
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 3))
      0: return rand64();
      1: return 64'($signed($urandom_range(0, 200)) - 100);
      2: return spl_cnt ? spl_tab[$urandom_range(0, spl_cnt - 1)] : 64'd0;
      default: return {1'b1, 63'($urandom())};
    endcase
  endfunction

  task automatic read_everything();
    for (int i = 0; i <= spl_cnt; i++) send_cmd(smp_pkg::CMD_RD_START, '0, 12'(i));
    for (int i = 0; i <= val_cnt; i++) send_cmd(smp_pkg::CMD_RD_OUT, '0, 12'(i));
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        result_t e;
        e = expected_q.pop_front();
        if (read_data_o !== e.data) begin
          $error("read_data expected %h got %h", e.data, read_data_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d got %0d", e.status, status_o);
          errors++;
        end
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 1000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // extremes, empty-state errors and unused commands
  task automatic test_directed();
    send_cmd(smp_pkg::CMD_PARTITION);
    send_cmd(smp_pkg::CMD_RD_START, '0, 12'd0);
    send_cmd(smp_pkg::CMD_RD_OUT, '0, 12'hfff);
    send_cmd(smp_pkg::CMD_NOP6, rand64(), 12'hfff);
    send_cmd(smp_pkg::CMD_NOP7);
    send_cmd(smp_pkg::CMD_LOAD_SPL, 64'h8000_0000_0000_0000);
    send_cmd(smp_pkg::CMD_PARTITION);
    send_cmd(smp_pkg::CMD_RD_START, '0, 12'd0);
    send_cmd(smp_pkg::CMD_RD_START, '0, 12'd1);
    send_cmd(smp_pkg::CMD_LOAD_SPL, 64'd0);
    send_cmd(smp_pkg::CMD_LOAD_SPL, 64'h7fff_ffff_ffff_ffff);
    send_cmd(smp_pkg::CMD_LOAD_VAL, 64'h8000_0000_0000_0000);
    send_cmd(smp_pkg::CMD_LOAD_VAL, 64'h7fff_ffff_ffff_ffff);
    send_cmd(smp_pkg::CMD_LOAD_VAL, 64'hffff_ffff_ffff_ffff);
    send_cmd(smp_pkg::CMD_LOAD_VAL, 64'd0);
    send_cmd(smp_pkg::CMD_RD_OUT, '0, 12'd0);
    send_cmd(smp_pkg::CMD_PARTITION);
    read_everything();
    send_cmd(smp_pkg::CMD_CLEAR);
  endtask

  // unsorted splitters: search still lands in range
  task automatic test_unsorted();
    for (int i = 0; i < 7; i++) send_cmd(smp_pkg::CMD_LOAD_SPL, pick_value());
    for (int i = 0; i < 20; i++) send_cmd(smp_pkg::CMD_LOAD_VAL, pick_value());
    send_cmd(smp_pkg::CMD_PARTITION);
    read_everything();
    send_cmd(smp_pkg::CMD_CLEAR);
  endtask

  // random sessions: sorted splitters, values, partition, reads, some noise
  task automatic test_random_sessions();
    int n_spl;
    int n_val;
    int sent;
    logic signed [63:0] s;
    sent = 0;
    while (sent < 500) begin
      n_spl = $urandom_range(1, 12);
      n_val = $urandom_range(0, 24);
      s = $urandom_range(0, 3) == 0 ? rand64() : 64'($signed($urandom_range(0, 40)) - 60);
      for (int i = 0; i < n_spl; i++) begin
        send_cmd(smp_pkg::CMD_LOAD_SPL, s);
        s = s + 64'($urandom_range(0, 20));
      end
      for (int i = 0; i < n_val; i++) send_cmd(smp_pkg::CMD_LOAD_VAL, pick_value());
      if ($urandom_range(0, 7) == 0) send_cmd(smp_pkg::cmd_e'($urandom_range(0, 7)),
                                              rand64(), 12'($urandom()));
      send_cmd(smp_pkg::CMD_PARTITION);
      for (int i = 0; i < n_val + 3; i++)
        send_cmd($urandom_range(0, 1) ? smp_pkg::CMD_RD_OUT : smp_pkg::CMD_RD_START,
                 rand64(), 12'($urandom_range(0, n_val + 1)));
      if ($urandom_range(0, 3) == 0) send_cmd(smp_pkg::CMD_LOAD_VAL, rand64());
      sent += n_spl + 2 * n_val + 4;
      if ($urandom_range(0, 1)) send_cmd(smp_pkg::CMD_CLEAR);
    end
  endtask

  initial begin
    errors       = 0;
    idle_cycles  = 0;
    spl_cnt      = 0;
    val_cnt      = 0;
    part_ok      = 1'b0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    cmd_i        = smp_pkg::CMD_NOP6;
    data_word_i  = '0;
    read_index_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_unsorted();
    test_random_sessions();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
